### src/partition_comm_volume_macros.svh
// assertion macros for the communication volume meter
`ifndef PARTITION_COMM_VOLUME_MACROS_SVH
`define PARTITION_COMM_VOLUME_MACROS_SVH
`ifndef NO_ASSERTIONS
// property that holds at every edge outside reset
`define PCV_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// implication, consequent checked in the next cycle
`define PCV_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define PCV_ASSERT(lbl, clk, rst, prop, msg)
`define PCV_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

### src/pcv_pkg.sv
`default_nettype none
package pcv_pkg;

   localparam int MAX_BLOCKS  = 64;
   localparam int VOLUME_BITS = 32;
   localparam int ADDR_BITS   = $clog2(MAX_BLOCKS);
   localparam int COUNT_BITS  = $clog2(MAX_BLOCKS + 1);
   localparam int BLOCK_BITS  = 6;
   localparam int CFG_BITS    = 7;
   localparam int OUT_BITS    = 32;

   localparam logic [CFG_BITS-1:0]    CFG_COUNT_RESET = CFG_BITS'(2);
   localparam logic [VOLUME_BITS-1:0] VOLUME_MAX      = '1;

   typedef logic [VOLUME_BITS-1:0] vol_type;
   typedef logic [ADDR_BITS-1:0]   addr_type;
   typedef logic [COUNT_BITS-1:0]  count_type;
   typedef logic [OUT_BITS-1:0]    out_type;

   // control from the sequencer to the report accumulators
   typedef struct packed {
      logic acc;
      logic clear;
   } rpt_ctl_type;

   function automatic vol_type sat_inc(input vol_type v);
      vol_type r;
      if (v == VOLUME_MAX) begin
         r = v;
      end else begin
         r = v + VOLUME_BITS'(1);
      end
      return r;
   endfunction

   function automatic out_type out_clamp(input vol_type v);
      out_type r;
      if ((v >> OUT_BITS) != '0) begin
         r = '1;
      end else begin
         r = OUT_BITS'(v);
      end
      return r;
   endfunction

endpackage
`default_nettype wire

### src/pcv_vol_ram.sv
`default_nettype none
module pcv_vol_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read returns the old contents on a same-address write
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

### src/pcv_report.sv
`default_nettype none
module pcv_report (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire pcv_pkg::rpt_ctl_type ctl,
   input  wire pcv_pkg::vol_type    value,
   output pcv_pkg::vol_type         max_out,
   output pcv_pkg::vol_type         min_out,
   output pcv_pkg::vol_type         total_out
);
   import pcv_pkg::*;

   vol_type                max_ff, max_in;
   vol_type                min_ff, min_in;
   vol_type                total_ff, total_in;
   logic [VOLUME_BITS:0]   sum;

   assign sum = {1'b0, total_ff} + {1'b0, value};

   always_comb begin
      max_in   = max_ff;
      min_in   = min_ff;
      total_in = total_ff;
      if (ctl.clear) begin
         max_in   = '0;
         min_in   = VOLUME_MAX;
         total_in = '0;
      end else if (ctl.acc) begin
         if (value > max_ff) begin
            max_in = value;
         end
         if (value < min_ff) begin
            min_in = value;
         end
         // saturate on carry out
         total_in = sum[VOLUME_BITS] ? VOLUME_MAX : sum[VOLUME_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff   <= '0;
         min_ff   <= VOLUME_MAX;
         total_ff <= '0;
      end else begin
         max_ff   <= max_in;
         min_ff   <= min_in;
         total_ff <= total_in;
      end
   end

   assign max_out   = max_ff;
   assign min_out   = min_ff;
   assign total_out = total_ff;

endmodule
`default_nettype wire

### src/partition_comm_volume.sv
`default_nettype none
// channel   direction  handshake                contents
// req       in         req_valid / req_ready    one edge: source and target block, end marks
// rsp       out        rsp_valid / rsp_ready    max, min and total volume of the graph
// csr       in         csr_wr_en                block_count, 7 bits
//
// edge requests are accepted in ST_RUN and may follow back to back there
// a request with the graph end mark holds off further requests while the report is built over
// block_count held to 1..64: a drain state for the last volume write, one ram read per block,
// a state for the final accumulate, then the result register load, held while rsp stalls
// reset is synchronous; the volume ram needs no clearing pass, per-entry valid bits
// make unwritten entries read as zero and are cleared together after each report
module partition_comm_volume (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic [pcv_pkg::BLOCK_BITS-1:0] req_source_block,
   input  wire logic [pcv_pkg::BLOCK_BITS-1:0] req_target_block,
   input  wire logic                           req_node_last_edge,
   input  wire logic                           req_graph_last_edge,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic      [pcv_pkg::OUT_BITS-1:0]   rsp_max_volume,
   output logic      [pcv_pkg::OUT_BITS-1:0]   rsp_min_volume,
   output logic      [pcv_pkg::OUT_BITS-1:0]   rsp_total_volume,
   input  wire logic                           csr_wr_en,
   input  wire logic [pcv_pkg::CFG_BITS-1:0]   csr_wr_data
);
   import pcv_pkg::*;

   `include "partition_comm_volume_macros.svh"

   // sequencer states
   typedef enum logic [4:0] {
      ST_RUN    = 5'b00001,  // taking edge requests
      ST_DRAIN  = 5'b00010,  // last edge's volume write lands
      ST_WALK   = 5'b00100,  // one volume read per block
      ST_LAST   = 5'b01000,  // final read data accumulated
      ST_REPORT = 5'b10000   // load result register
   } state_type;

   state_type              state_ff, state_in;
   logic [CFG_BITS-1:0]    block_count_ff, block_count_in;
   count_type              ecount;
   count_type              walk_idx_ff, walk_idx_in;

   logic [MAX_BLOCKS-1:0]  seen_ff, seen_in;
   logic [MAX_BLOCKS-1:0]  blk_valid_ff, blk_valid_in;

   // read stage
   logic                   accept;
   logic                   hit;
   addr_type               src_addr;
   addr_type               dst_addr;
   logic                   rd_en;
   addr_type               rd_addr;
   vol_type                rd_data;

   // modify / write stage
   logic                   s1_inc_ff, s1_inc_in;
   logic                   s1_walk_ff, s1_walk_in;
   addr_type               s1_addr_ff;
   logic                   s1_vld_ff;
   vol_type                s1_cur;
   logic                   wr_en;
   vol_type                wr_data;

   // last write, forwarded into the next read-modify-write
   logic                   fwd_vld_ff;
   addr_type               fwd_addr_ff;
   vol_type                fwd_data_ff;

   // report path
   rpt_ctl_type            rpt_ctl;
   vol_type                acc_max;
   vol_type                acc_min;
   vol_type                acc_total;
   logic                   rpt_load;
   logic                   rsp_valid_ff, rsp_valid_in;
   out_type                rsp_max_ff;
   out_type                rsp_min_ff;
   out_type                rsp_total_ff;

   // ---------------------------------------------------------------------------------
   // configuration and effective block count
   // ---------------------------------------------------------------------------------
   assign block_count_in = csr_wr_en ? csr_wr_data : block_count_ff;

   always_comb begin
      if (block_count_ff == '0) begin
         ecount = COUNT_BITS'(1);
      end else if (int'(block_count_ff) > MAX_BLOCKS) begin
         ecount = COUNT_BITS'(MAX_BLOCKS);
      end else begin
         ecount = COUNT_BITS'(block_count_ff);
      end
   end

   // ---------------------------------------------------------------------------------
   // edge intake: seen bitmap decides whether the source volume grows
   // ---------------------------------------------------------------------------------
   assign req_ready = (state_ff == ST_RUN);
   assign accept    = req_valid && req_ready;
   assign src_addr  = ADDR_BITS'(req_source_block);
   assign dst_addr  = ADDR_BITS'(req_target_block);

   // new foreign target inside the configured range
   assign hit = accept && (req_source_block < ecount) && (req_target_block < ecount) &&
                (req_target_block != req_source_block) && !seen_ff[dst_addr];

   always_comb begin
      seen_in = seen_ff;
      if (accept) begin
         if (req_node_last_edge || req_graph_last_edge) begin
            seen_in = '0;
         end else if (hit) begin
            seen_in[dst_addr] = 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // volume ram: read on hit or walk, then increment and write back in the next cycle, not later
   // ---------------------------------------------------------------------------------
   assign rd_en      = hit || (state_ff == ST_WALK);
   assign rd_addr    = hit ? src_addr : walk_idx_ff[ADDR_BITS-1:0];
   assign s1_inc_in  = hit;
   assign s1_walk_in = (state_ff == ST_WALK);

   pcv_vol_ram #(
      .DEPTH (MAX_BLOCKS),
      .WIDTH (VOLUME_BITS)
   ) u_vol_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (s1_addr_ff),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // ram read misses a write that landed at the same edge; take the forwarded value
   always_comb begin
      if (fwd_vld_ff && (fwd_addr_ff == s1_addr_ff)) begin
         s1_cur = fwd_data_ff;
      end else if (s1_vld_ff) begin
         s1_cur = rd_data;
      end else begin
         s1_cur = '0;
      end
   end

   assign wr_en   = s1_inc_ff;
   assign wr_data = sat_inc(s1_cur);

   // valid bits: set by each write, all cleared when the result register is loaded
   always_comb begin
      blk_valid_in = blk_valid_ff;
      if (rpt_load) begin
         blk_valid_in = '0;
      end else if (wr_en) begin
         blk_valid_in[s1_addr_ff] = 1'b1;
      end
   end

   // ---------------------------------------------------------------------------------
   // sequencer
   // ---------------------------------------------------------------------------------
   assign rpt_load = (state_ff == ST_REPORT) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in    = state_ff;
      walk_idx_in = walk_idx_ff;
      case (state_ff)
         ST_RUN: begin
            if (accept && req_graph_last_edge) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in    = ST_WALK;
            walk_idx_in = '0;
         end
         ST_WALK: begin
            if (walk_idx_ff == ecount - COUNT_BITS'(1)) begin
               state_in = ST_LAST;
            end else begin
               walk_idx_in = walk_idx_ff + COUNT_BITS'(1);
            end
         end
         ST_LAST: begin
            state_in = ST_REPORT;
         end
         ST_REPORT: begin
            if (rpt_load) begin
               state_in    = ST_RUN;
               walk_idx_in = '0;
            end
         end
         default: begin
            state_in    = ST_RUN;
            walk_idx_in = '0;
         end
      endcase
   end

   // ---------------------------------------------------------------------------------
   // report accumulators
   // ---------------------------------------------------------------------------------
   assign rpt_ctl.acc   = s1_walk_ff;
   assign rpt_ctl.clear = rpt_load;

   pcv_report u_report (
      .clock     (clock),
      .reset     (reset),
      .ctl       (rpt_ctl),
      .value     (s1_cur),
      .max_out   (acc_max),
      .min_out   (acc_min),
      .total_out (acc_total)
   );

   // result register frees the accumulators as soon as it is loaded
   always_comb begin
      if (rpt_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // ---------------------------------------------------------------------------------
   // registers
   // ---------------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_RUN;
         block_count_ff <= CFG_COUNT_RESET;
         walk_idx_ff    <= '0;
         seen_ff        <= '0;
         blk_valid_ff   <= '0;
         s1_inc_ff      <= 1'b0;
         s1_walk_ff     <= 1'b0;
         fwd_vld_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         block_count_ff <= block_count_in;
         walk_idx_ff    <= walk_idx_in;
         seen_ff        <= seen_in;
         blk_valid_ff   <= blk_valid_in;
         s1_inc_ff      <= s1_inc_in;
         s1_walk_ff     <= s1_walk_in;
         fwd_vld_ff     <= wr_en;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (rd_en) begin
         s1_addr_ff <= rd_addr;
         s1_vld_ff  <= blk_valid_ff[rd_addr];
      end
      if (wr_en) begin
         fwd_addr_ff <= s1_addr_ff;
         fwd_data_ff <= wr_data;
      end
      if (rpt_load) begin
         rsp_max_ff   <= out_clamp(acc_max);
         rsp_min_ff   <= out_clamp(acc_min);
         rsp_total_ff <= out_clamp(acc_total);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_max_volume   = rsp_max_ff;
   assign rsp_min_volume   = rsp_min_ff;
   assign rsp_total_volume = rsp_total_ff;

   // ---------------------------------------------------------------------------------
   // checks
   // ---------------------------------------------------------------------------------
   `PCV_ASSERT(a_walk_inc_excl, clock, reset, !(s1_walk_ff && s1_inc_ff), "walk and update overlap")
   `PCV_ASSERT(a_walk_range, clock, reset, (state_ff != ST_WALK) || (walk_idx_ff < ecount), "walk index out of range")
   `PCV_ASSERT_NEXT(a_valid_clr, clock, reset, rpt_load, blk_valid_ff == '0, "volumes not cleared after report")
   `PCV_ASSERT_NEXT(a_seen_clr, clock, reset, accept && (req_node_last_edge || req_graph_last_edge), seen_ff == '0, "seen map not cleared at node end")

endmodule
`default_nettype wire

### test/partition_comm_volume_tb.sv
`timescale 1ns / 1ps

// edge stream in, one volume report per graph out
// a local copy of the meter predicts every report, the checker compares field by field
module testbench;

   localparam int NUM_BLOCKS      = pcv_pkg::MAX_BLOCKS;
   localparam int BLOCK_ID_MAX    = 2 ** pcv_pkg::BLOCK_BITS - 1;
   localparam longint unsigned VOL_LIMIT = 64'({pcv_pkg::VOLUME_BITS{1'b1}});
   localparam longint unsigned OUT_LIMIT = 64'({pcv_pkg::OUT_BITS{1'b1}});
   // covers the report walk over the full table, keep some margin on top
   localparam int SETTLE_CYCLES   = NUM_BLOCKS + 8;
   // cycles without a handshake on either channel before the run is called hung
   localparam int STALL_LIMIT     = 4000;
   localparam int RSP_HOLD_CYCLES = 400;
   localparam int MAX_LOGGED      = 10;
   localparam int RANDOM_ITEMS    = 1400;
   localparam int RANDOM_PHASES   = 9;

   typedef logic [pcv_pkg::BLOCK_BITS-1:0] block_id_type;
   typedef logic [pcv_pkg::OUT_BITS-1:0]   volume_out_type;
   typedef logic [pcv_pkg::CFG_BITS-1:0]   count_cfg_type;

   typedef struct {
      volume_out_type max_v;
      volume_out_type min_v;
      volume_out_type total_v;
   } volume_report_type;

   logic           clock;
   logic           reset;
   logic           req_valid;
   logic           req_ready;
   block_id_type   req_source_block;
   block_id_type   req_target_block;
   logic           req_node_last_edge;
   logic           req_graph_last_edge;
   logic           rsp_valid;
   logic           rsp_ready;
   volume_out_type rsp_max_volume;
   volume_out_type rsp_min_volume;
   volume_out_type rsp_total_volume;
   logic           csr_wr_en;
   count_cfg_type  csr_wr_data;

   // meter copy: block count, per-node seen bitmap, per-block volumes
   count_cfg_type       count_setting;
   bit [NUM_BLOCKS-1:0] seen_map;
   longint unsigned     block_vol [NUM_BLOCKS];
   volume_report_type   pending_reports [$];

   int edges_sent;
   int reports_seen;
   int settings_used;
   int fail_count;
   int rsp_hold_cycles;
   bit req_gaps_on;
   bit rsp_stalls_on;

   partition_comm_volume i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_source_block    (req_source_block),
      .req_target_block    (req_target_block),
      .req_node_last_edge  (req_node_last_edge),
      .req_graph_last_edge (req_graph_last_edge),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_max_volume      (rsp_max_volume),
      .rsp_min_volume      (rsp_min_volume),
      .rsp_total_volume    (rsp_total_volume),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data)
   );

   // 20 ns clock
   initial begin : clock_gen
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // meter copy
   // ------------------------------------------------------------------

   // count 0 behaves as one block, anything above the table size as the full table
   function automatic int active_blocks();
      if (count_setting == 0) return 1;
      if (count_setting > NUM_BLOCKS) return NUM_BLOCKS;
      return int'(count_setting);
   endfunction

   function automatic volume_out_type to_out(input longint unsigned v);
      return (v > OUT_LIMIT) ? volume_out_type'(OUT_LIMIT) : volume_out_type'(v);
   endfunction

   // one accepted edge; on graph end queue the report and clear the volumes
   function automatic void meter_edge(input block_id_type src, input block_id_type tgt,
                                      input logic node_last, input logic graph_last);
      int n;
      int i;
      longint unsigned vmax;
      longint unsigned vmin;
      longint unsigned vsum;
      longint unsigned s;
      volume_report_type rep;
      n = active_blocks();
      // only a foreign block not yet seen for this node adds volume
      if (src < n && tgt < n && tgt != src && !seen_map[tgt]) begin
         seen_map[tgt] = 1'b1;
         if (block_vol[src] != VOL_LIMIT) block_vol[src] = block_vol[src] + 1;
      end
      // graph end also ends the node
      if (node_last || graph_last) seen_map = '0;
      if (graph_last) begin
         vmax = 0;
         vmin = VOL_LIMIT;
         vsum = 0;
         for (i = 0; i < n; i++) begin
            if (block_vol[i] > vmax) vmax = block_vol[i];
            if (block_vol[i] < vmin) vmin = block_vol[i];
            s = vsum + block_vol[i];
            vsum = (s < vsum || s > VOL_LIMIT) ? VOL_LIMIT : s;
         end
         rep.max_v   = to_out(vmax);
         rep.min_v   = to_out(vmin);
         rep.total_v = to_out(vsum);
         pending_reports.push_back(rep);
         foreach (block_vol[k]) block_vol[k] = 0;
      end
   endfunction

   // ------------------------------------------------------------------
   // request side
   // ------------------------------------------------------------------

   // mostly back to back, some short gaps, a few long ones
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) return 0;
      if (roll < 95) return $urandom_range(1, 3);
      return $urandom_range(15, 60);
   endfunction

   // drive at the falling edge, hold until taken at a rising edge
   task automatic offer_edge(input block_id_type src, input block_id_type tgt,
                             input logic node_last, input logic graph_last);
      @(negedge clock);
      req_valid           = 1'b1;
      req_source_block    = src;
      req_target_block    = tgt;
      req_node_last_edge  = node_last;
      req_graph_last_edge = graph_last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      meter_edge(src, tgt, node_last, graph_last);
      edges_sent++;
   endtask

   // valid dropped for a gap set by n, nothing when n is 0 so valid stays up
   task automatic idle_req(input int n);
      if (n > 0) begin
         @(negedge clock);
         req_valid = 1'b0;
         repeat (n - 1) @(negedge clock);
      end
   endtask

   task automatic pause_req();
      idle_req(req_gaps_on ? pick_gap() : 0);
   endtask

   // stop offering and wait for every queued report
   task automatic drain_reports();
      idle_req(1);
      while (pending_reports.size() != 0) @(posedge clock);
   endtask

   // a write only once the meter is quiet, including any edge still in the pipe
   task automatic set_block_count(input count_cfg_type value);
      drain_reports();
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_wr_en     = 1'b1;
      csr_wr_data   = value;
      count_setting = value;
      @(negedge clock);
      csr_wr_en = 1'b0;
      settings_used++;
   endtask

   // node-major graph with random fan-out, a few stray blocks and broken node marks
   task automatic send_random_graph();
      int n;
      int nodes;
      int fanout;
      block_id_type src;
      block_id_type tgt;
      logic node_end;
      logic graph_end;
      n = active_blocks();
      nodes = $urandom_range(1, 8);
      for (int nd = 0; nd < nodes; nd++) begin
         fanout = $urandom_range(1, 6);
         src = ($urandom_range(0, 19) == 0) ? block_id_type'($urandom_range(0, BLOCK_ID_MAX))
                                             : block_id_type'($urandom_range(0, n - 1));
         for (int ed = 0; ed < fanout; ed++) begin
            // source switching inside a node, bitmap stays shared
            if ($urandom_range(0, 15) == 0) src = block_id_type'($urandom_range(0, n - 1));
            tgt = ($urandom_range(0, 9) == 0) ? block_id_type'($urandom_range(0, BLOCK_ID_MAX))
                                               : block_id_type'($urandom_range(0, n - 1));
            node_end  = (ed == fanout - 1);
            graph_end = node_end && (nd == nodes - 1);
            // dropped or extra node end mark
            if ($urandom_range(0, 29) == 0) node_end = ~node_end;
            offer_edge(src, tgt, node_end, graph_end);
            pause_req();
         end
      end
   endtask

   // ------------------------------------------------------------------
   // result side
   // ------------------------------------------------------------------

   // random stalls, or one long hold-off when a test asks for it
   initial begin : rsp_driver
      int n;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_cycles > 0) begin
            rsp_ready = 1'b0;
            repeat (rsp_hold_cycles) @(negedge clock);
            rsp_hold_cycles = 0;
            rsp_ready = 1'b1;
         end else begin
            n = rsp_stalls_on ? pick_gap() : 0;
            if (n > 0) begin
               rsp_ready = 1'b0;
               repeat (n - 1) @(negedge clock);
            end else begin
               rsp_ready = 1'b1;
            end
         end
      end
   end

   function automatic void check_field(input string field, input volume_out_type want,
                                       input volume_out_type got);
      if (want !== got) begin
         fail_count++;
         if (fail_count <= MAX_LOGGED)
            $display("report %0d %s: expected %0d, got %0d", reports_seen, field, want, got);
      end
   endfunction

   // each accepted report against the oldest prediction
   always @(posedge clock) begin : report_check
      volume_report_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         reports_seen++;
         if (pending_reports.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_LOGGED)
               $display("report %0d arrived with none pending: max %0d min %0d total %0d",
                        reports_seen, rsp_max_volume, rsp_min_volume, rsp_total_volume);
         end else begin
            want = pending_reports.pop_front();
            check_field("max_volume", want.max_v, rsp_max_volume);
            check_field("min_volume", want.min_v, rsp_min_volume);
            check_field("total_volume", want.total_v, rsp_total_volume);
         end
      end
   end

   // hang detection: cycles in which neither channel moves a request
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
         else quiet++;
      end
      $display("no handshake for %0d cycles, %0d reports still pending",
               STALL_LIMIT, pending_reports.size());
      $display("simulation failed");
      $finish;
   end

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------

   // reset block count of two: repeat target, own block, stray block, node end
   task automatic test_reset_count();
      offer_edge(0, 1, 1'b0, 1'b0);
      offer_edge(0, 1, 1'b0, 1'b0);
      offer_edge(0, 0, 1'b0, 1'b0);
      offer_edge(0, 5, 1'b1, 1'b0);
      offer_edge(1, 0, 1'b0, 1'b1);
   endtask

   // full table, lowest and highest block ids
   task automatic test_field_extremes();
      set_block_count(count_cfg_type'(NUM_BLOCKS));
      offer_edge(BLOCK_ID_MAX, 0, 1'b0, 1'b0);
      offer_edge(0, BLOCK_ID_MAX, 1'b1, 1'b0);
      offer_edge(BLOCK_ID_MAX, BLOCK_ID_MAX, 1'b0, 1'b0);
      offer_edge(BLOCK_ID_MAX, BLOCK_ID_MAX - 1, 1'b0, 1'b0);
      offer_edge(0, 0, 1'b1, 1'b1);
   endtask

   // blocks past the count change nothing, but their end marks still count
   task automatic test_out_of_range();
      set_block_count(3);
      offer_edge(1, 2, 1'b0, 1'b0);
      offer_edge(5, 1, 1'b0, 1'b0);
      offer_edge(1, BLOCK_ID_MAX, 1'b1, 1'b0);
      offer_edge(1, 2, 1'b0, 1'b0);
      offer_edge(2, 60, 1'b0, 1'b1);
   endtask

   // new source mid-node sees the targets marked by the old one
   task automatic test_source_change();
      set_block_count(4);
      offer_edge(0, 2, 1'b0, 1'b0);
      offer_edge(1, 2, 1'b0, 1'b0);
      offer_edge(1, 0, 1'b0, 1'b0);
      offer_edge(2, 1, 1'b1, 1'b0);
      offer_edge(3, 3, 1'b0, 1'b1);
   endtask

   // count of zero acts as one, counts past the table act as the full table
   task automatic test_count_limits();
      set_block_count(0);
      offer_edge(0, 0, 1'b0, 1'b1);
      offer_edge(1, 0, 1'b0, 1'b1);
      set_block_count('1);
      offer_edge(BLOCK_ID_MAX, 10, 1'b0, 1'b1);
      set_block_count(count_cfg_type'(NUM_BLOCKS + 1));
      offer_edge(10, BLOCK_ID_MAX, 1'b1, 1'b1);
   endtask

   // count lowered mid-graph: report walks the new count, all volumes clear
   task automatic test_mid_graph_count();
      set_block_count(8);
      offer_edge(6, 7, 1'b0, 1'b0);
      offer_edge(7, 6, 1'b1, 1'b0);
      offer_edge(7, 1, 1'b0, 1'b0);
      set_block_count(4);
      offer_edge(0, 1, 1'b0, 1'b1);
      set_block_count(8);
      offer_edge(7, 7, 1'b0, 1'b1);
   endtask

   // long receiver hold-off while the sender keeps pushing graphs
   task automatic test_rsp_backpressure();
      set_block_count(16);
      req_gaps_on     = 1'b0;
      rsp_hold_cycles = RSP_HOLD_CYCLES;
      repeat (6) send_random_graph();
      drain_reports();
      req_gaps_on = 1'b1;
   endtask

   // sender waits for each report before the next graph
   task automatic test_drain_pause();
      repeat (3) begin
         send_random_graph();
         drain_reports();
      end
   endtask

   // phases over several block counts, extremes first, then a random one
   task automatic test_random_traffic();
      int counts [RANDOM_PHASES];
      int phase_end;
      counts = '{NUM_BLOCKS, 2, 1, 127, 0, 33, NUM_BLOCKS + 1, 5, -1};
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         if (counts[ph] < 0) set_block_count(count_cfg_type'($urandom_range(1, NUM_BLOCKS)));
         else set_block_count(count_cfg_type'(counts[ph]));
         // first phase runs with no idling on either side
         req_gaps_on   = (ph != 0) && ($urandom_range(0, 3) != 0);
         rsp_stalls_on = (ph != 0) && ($urandom_range(0, 3) != 0);
         phase_end = edges_sent + RANDOM_ITEMS / RANDOM_PHASES;
         while (edges_sent < phase_end) begin
            if ($urandom_range(0, 9) == 0) begin
               // noise: any ids, any node mark, rare early graph end
               offer_edge(block_id_type'($urandom_range(0, BLOCK_ID_MAX)),
                          block_id_type'($urandom_range(0, BLOCK_ID_MAX)),
                          1'($urandom_range(0, 1)), $urandom_range(0, 7) == 0);
               pause_req();
            end else begin
               send_random_graph();
            end
         end
      end
   endtask

   // ------------------------------------------------------------------
   // sequence
   // ------------------------------------------------------------------

   initial begin : main_sequence
      reset               = 1'b1;
      req_valid           = 1'b0;
      req_source_block    = '0;
      req_target_block    = '0;
      req_node_last_edge  = 1'b0;
      req_graph_last_edge = 1'b0;
      csr_wr_en           = 1'b0;
      csr_wr_data         = '0;
      count_setting       = pcv_pkg::CFG_COUNT_RESET;
      seen_map            = '0;
      foreach (block_vol[k]) block_vol[k] = 0;
      edges_sent      = 0;
      reports_seen    = 0;
      settings_used   = 0;
      fail_count      = 0;
      rsp_hold_cycles = 0;
      req_gaps_on     = 1'b1;
      rsp_stalls_on   = 1'b1;

      repeat (9) @(negedge clock);
      reset = 1'b0;

      test_reset_count();
      test_field_extremes();
      test_out_of_range();
      test_source_change();
      test_count_limits();
      test_mid_graph_count();
      test_rsp_backpressure();
      test_drain_pause();
      test_random_traffic();

      // all stimulus in, let the last reports and the report walk finish
      drain_reports();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_reports.size() != 0) begin
         fail_count += pending_reports.size();
         $display("%0d reports never arrived", pending_reports.size());
      end

      $display("covered %0d edges and %0d volume reports over %0d block count writes,",
               edges_sent, reports_seen, settings_used);
      $display("with stray blocks, shared node bitmaps and a long result hold-off");
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("%0d mismatches", fail_count);
         $display("simulation failed");
      end
      $finish;
   end

endmodule
